@@ src/pfe_pkg.sv @@
// Shared constants, register map, filter codes and types of the PNG filter encoder.
package pfe_pkg;

  localparam int MAX_ROW_BYTES = 8192;
  localparam int MAX_CHANNELS  = 4;

  localparam int BYTE_W = 8;
  localparam int FT_W   = 3;
  localparam int BPP_W  = 3;
  localparam int IW_W   = 12;
  localparam int IH_W   = 16;

  localparam int POS_W     = $clog2(MAX_ROW_BYTES);
  localparam int STRIDE_W  = POS_W + 1;
  localparam int BPP_EFF_W = $clog2(MAX_CHANNELS + 1);
  localparam int CH_IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;
  localparam int ADDR_W    = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_TYPE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd3;

  localparam logic [FT_W-1:0] FT_NONE    = 3'd0;
  localparam logic [FT_W-1:0] FT_SUB     = 3'd1;
  localparam logic [FT_W-1:0] FT_UP      = 3'd2;
  localparam logic [FT_W-1:0] FT_AVERAGE = 3'd3;
  localparam logic [FT_W-1:0] FT_PAETH   = 3'd4;

  localparam logic [FT_W-1:0]  FT_RESET  = FT_NONE;
  localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
  localparam logic [IW_W-1:0]  IW_RESET  = 12'd1;
  localparam logic [IH_W-1:0]  IH_RESET  = 16'd1;

  // Neighbor bytes around the current sample, already zeroed outside the image.
  typedef struct packed {
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] up;
    logic [BYTE_W-1:0] upleft;
  } nbr_t;

endpackage

@@ src/pfe_in_if.sv @@
// Input sample channel: valid/ready handshake with one raw sample byte.
interface pfe_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfe_pkg::BYTE_W-1:0]  sample_byte;

  modport source (output valid, output sample_byte, input ready);
  modport sink   (input valid, input sample_byte, output ready);
endinterface

@@ src/pfe_out_if.sv @@
// Result channel: valid/ready handshake with filtered byte, tag and framing flags.
interface pfe_out_if;
  logic                        valid;
  logic                        ready;
  logic [pfe_pkg::BYTE_W-1:0]  out_byte;
  logic                        is_tag;
  logic                        last;
  logic                        end_of_image;

  modport source (output valid, output out_byte, output is_tag, output last,
                  output end_of_image, input ready);
  modport sink   (input valid, input out_byte, input is_tag, input last,
                  input end_of_image, output ready);
endinterface

@@ src/png_scanline_filter_encoder_unit.sv @@
// Top level of the PNG scanline filter encoder: config port, counters, pipeline.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------------
//  in_ch    | in  | valid & ready        | sample_byte[7:0]
//  out_ch   | out | valid & ready        | out_byte[7:0], is_tag, last, end_of_image
//  config   | in  | psel&penable&pwrite  | paddr[3:0], pwdata[31:0], prdata[31:0]
//
//  One sample is accepted per cycle unless out_ch stalls or a row tag waits. A
//  sample at the start of a row gives two results (tag, then filtered byte),
//  holding the output stage until both are taken; every other sample gives one.
//  Each sample is registered in the predict stage, with the line store's registered read, then in the output stage.
//  Reset clears the counters and pipeline valids; the line store and history
//  registers hold garbage until written by the first row.
//  A stall on out_ch holds the output stage, then the predict stage, then
//  in_ch.ready drops.
module png_scanline_filter_encoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  pfe_in_if.sink                         in_ch,
  pfe_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfe_pkg::ADDR_W-1:0]     paddr,
  input  logic [pfe_pkg::DATA_W-1:0]     pwdata,
  output logic [pfe_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  localparam int PROD_W = pfe_pkg::BPP_EFF_W + pfe_pkg::IW_W;
  localparam int CMP_W  = (PROD_W > pfe_pkg::STRIDE_W) ? PROD_W : pfe_pkg::STRIDE_W;
  localparam int ROW_W  = pfe_pkg::IH_W + 1;
  localparam int BPP_CMP_W = pfe_pkg::BPP_W + 1;

  // Configuration registers
  logic [pfe_pkg::FT_W-1:0]  ft_r;
  logic [pfe_pkg::BPP_W-1:0] bpp_r;
  logic [pfe_pkg::IW_W-1:0]  iw_r;
  logic [pfe_pkg::IH_W-1:0]  ih_r;
  logic                      cfg_wr;

  // Row / byte counters
  logic [pfe_pkg::POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [pfe_pkg::IH_W-1:0]  row_r, row_nxt;

  // Decoded configuration
  logic [pfe_pkg::FT_W-1:0]      ft_eff;
  logic [BPP_CMP_W-1:0]          bpp_wide;
  logic [BPP_CMP_W-1:0]          bpp_clamp;
  logic [pfe_pkg::BPP_EFF_W-1:0] bpp_eff;
  logic [pfe_pkg::CH_IDX_W-1:0]  ch_idx;
  logic [pfe_pkg::IW_W-1:0]      w_eff;
  logic [pfe_pkg::IH_W-1:0]      h_eff;
  logic [PROD_W-1:0]             prod;
  logic [pfe_pkg::STRIDE_W-1:0]  stride;

  // Position of the accepted sample
  logic [pfe_pkg::POS_W-1:0]    pos;
  logic [pfe_pkg::STRIDE_W-1:0] pos_inc;
  logic [ROW_W-1:0]             row_a, row_c, row_b;
  logic                         at_edge;
  logic                         eoi;

  // Histories
  logic [pfe_pkg::BYTE_W-1:0] left_hist_r   [pfe_pkg::MAX_CHANNELS];
  logic [pfe_pkg::BYTE_W-1:0] upleft_hist_r [pfe_pkg::MAX_CHANNELS];

  // Predict stage
  logic                          s1_valid_r;
  logic                          s1_pos0_r;
  logic                          s1_edge_r;
  logic                          s1_row0_r;
  logic                          s1_eoi_r;
  logic [pfe_pkg::FT_W-1:0]      s1_ft_r;
  logic [pfe_pkg::CH_IDX_W-1:0]  s1_idx_r;
  logic [pfe_pkg::BYTE_W-1:0]    s1_left_r;
  logic [pfe_pkg::BYTE_W-1:0]    s1_target_r;
  logic [pfe_pkg::BYTE_W-1:0]    mem_rdata;
  logic [pfe_pkg::BYTE_W-1:0]    up_val;
  pfe_pkg::nbr_t                 nbr;
  logic [pfe_pkg::BYTE_W-1:0]    diff;

  // Output stage
  logic                          o_valid_r;
  logic                          o_tag_r;
  logic                          o_eoi_r;
  logic [pfe_pkg::FT_W-1:0]      o_ft_r;
  logic [pfe_pkg::BYTE_W-1:0]    o_byte_r;

  logic in_xfer, out_xfer, o_free, s1_adv;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ft_r  <= pfe_pkg::FT_RESET;
      bpp_r <= pfe_pkg::BPP_RESET;
      iw_r  <= pfe_pkg::IW_RESET;
      ih_r  <= pfe_pkg::IH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[pfe_pkg::ADDR_W-1:2])
        pfe_pkg::REG_FILTER_TYPE:     ft_r  <= pwdata[pfe_pkg::FT_W-1:0];
        pfe_pkg::REG_BYTES_PER_PIXEL: bpp_r <= pwdata[pfe_pkg::BPP_W-1:0];
        pfe_pkg::REG_IMAGE_WIDTH:     iw_r  <= pwdata[pfe_pkg::IW_W-1:0];
        pfe_pkg::REG_IMAGE_HEIGHT:    ih_r  <= pwdata[pfe_pkg::IH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[pfe_pkg::ADDR_W-1:2])
      pfe_pkg::REG_FILTER_TYPE:     prdata = pfe_pkg::DATA_W'(ft_r);
      pfe_pkg::REG_BYTES_PER_PIXEL: prdata = pfe_pkg::DATA_W'(bpp_r);
      pfe_pkg::REG_IMAGE_WIDTH:     prdata = pfe_pkg::DATA_W'(iw_r);
      pfe_pkg::REG_IMAGE_HEIGHT:    prdata = pfe_pkg::DATA_W'(ih_r);
      default:                      prdata = '0;
    endcase
  end

  // -------------------------------------------------------- decoded settings
  // Undefined filter codes act as None; zero sizes act as one; pixel size
  // clamps to the channel count; the row length saturates at the line store.
  always_comb begin
    ft_eff   = (ft_r > pfe_pkg::FT_PAETH) ? pfe_pkg::FT_NONE : ft_r;
    bpp_wide = {1'b0, bpp_r};
    if (bpp_wide == '0) begin
      bpp_clamp = BPP_CMP_W'(1);
    end else if (bpp_wide > BPP_CMP_W'(pfe_pkg::MAX_CHANNELS)) begin
      bpp_clamp = BPP_CMP_W'(pfe_pkg::MAX_CHANNELS);
    end else begin
      bpp_clamp = bpp_wide;
    end
    bpp_eff = pfe_pkg::BPP_EFF_W'(bpp_clamp);
    ch_idx  = pfe_pkg::CH_IDX_W'(bpp_eff - pfe_pkg::BPP_EFF_W'(1));
    w_eff   = (iw_r == '0) ? pfe_pkg::IW_W'(1) : iw_r;
    h_eff   = (ih_r == '0) ? pfe_pkg::IH_W'(1) : ih_r;
    prod    = PROD_W'(bpp_eff) * PROD_W'(w_eff);
    if (CMP_W'(prod) > CMP_W'(pfe_pkg::MAX_ROW_BYTES)) begin
      stride = pfe_pkg::STRIDE_W'(pfe_pkg::MAX_ROW_BYTES);
    end else begin
      stride = pfe_pkg::STRIDE_W'(prod);
    end
  end

  // ---------------------------------------------------------- position logic
  always_comb begin
    // End the row early if the stored position no longer fits the stride,
    // and restart the image if the row is past the height.
    if (pfe_pkg::STRIDE_W'(byte_pos_r) >= stride) begin
      pos   = '0;
      row_a = ROW_W'(row_r) + ROW_W'(1);
    end else begin
      pos   = byte_pos_r;
      row_a = ROW_W'(row_r);
    end
    row_c   = (row_a >= ROW_W'(h_eff)) ? '0 : row_a;
    pos_inc = pfe_pkg::STRIDE_W'(pos) + pfe_pkg::STRIDE_W'(1);
    row_b   = row_c + ROW_W'(1);
    if (pos_inc >= stride) begin
      byte_pos_nxt = '0;
      row_nxt      = (row_b >= ROW_W'(h_eff)) ? '0 : pfe_pkg::IH_W'(row_b);
    end else begin
      byte_pos_nxt = pos_inc[pfe_pkg::POS_W-1:0];
      row_nxt      = pfe_pkg::IH_W'(row_c);
    end
    at_edge = pfe_pkg::STRIDE_W'(pos) < pfe_pkg::STRIDE_W'(bpp_eff);
    eoi     = (row_c == ROW_W'(h_eff) - ROW_W'(1)) && (pos_inc == stride);
  end

  // ---------------------------------------------------------------- handshake
  assign out_xfer     = out_ch.valid && out_ch.ready;
  assign o_free       = !o_valid_r || (out_xfer && !o_tag_r);
  assign s1_adv       = s1_valid_r && o_free;
  assign in_ch.ready  = !s1_valid_r || o_free;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      row_r      <= '0;
    end else if (in_xfer) begin
      byte_pos_r <= byte_pos_nxt;
      row_r      <= row_nxt;
    end
  end

  // Read the previous row's byte and overwrite it with this sample in the same
  // cycle; a one-byte row reads back its own last write on the next transfer.
  pfe_line_store u_line (
    .clk   (clk),
    .en    (in_xfer),
    .addr  (pos),
    .wdata (in_ch.sample_byte),
    .rdata (mem_rdata)
  );

  // Left history advances on each input transfer, newest first.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      left_hist_r[0] <= in_ch.sample_byte;
      for (int i = 1; i < pfe_pkg::MAX_CHANNELS; i++) begin
        left_hist_r[i] <= left_hist_r[i-1];
      end
    end
  end

  // ------------------------------------------------------------ predict stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pos0_r   <= (pos == '0);
      s1_edge_r   <= at_edge;
      s1_row0_r   <= (row_c == '0);
      s1_eoi_r    <= eoi;
      s1_ft_r     <= ft_eff;
      s1_idx_r    <= ch_idx;
      s1_left_r   <= at_edge ? '0 : left_hist_r[ch_idx];
      s1_target_r <= in_ch.sample_byte;
    end
  end

  assign up_val     = s1_row0_r ? '0 : mem_rdata;
  assign nbr.left   = s1_left_r;
  assign nbr.up     = up_val;
  assign nbr.upleft = (s1_edge_r || s1_row0_r) ? '0 : upleft_hist_r[s1_idx_r];

  // Up-left history advances once per sample as it leaves the predict stage.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      upleft_hist_r[0] <= up_val;
      for (int i = 1; i < pfe_pkg::MAX_CHANNELS; i++) begin
        upleft_hist_r[i] <= upleft_hist_r[i-1];
      end
    end
  end

  pfe_predict u_pred (
    .ft     (s1_ft_r),
    .nbr    (nbr),
    .target (s1_target_r),
    .diff   (diff)
  );

  // ------------------------------------------------------------- output stage
  // A row-start sample shows its tag first, then its filtered byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      o_tag_r   <= 1'b0;
    end else if (s1_adv) begin
      o_valid_r <= 1'b1;
      o_tag_r   <= s1_pos0_r;
    end else if (out_xfer) begin
      if (o_tag_r) begin
        o_tag_r <= 1'b0;
      end else begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_ft_r   <= s1_ft_r;
      o_byte_r <= diff;
      o_eoi_r  <= s1_eoi_r;
    end
  end

  assign out_ch.valid        = o_valid_r;
  assign out_ch.out_byte     = o_tag_r ? pfe_pkg::BYTE_W'(o_ft_r) : o_byte_r;
  assign out_ch.is_tag       = o_tag_r;
  assign out_ch.last         = !o_tag_r;
  assign out_ch.end_of_image = !o_tag_r && o_eoi_r;

endmodule

@@ src/pfe_line_store.sv @@
// Previous-row line store: single-port synchronous RAM, read-first, registered read.
module pfe_line_store (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pfe_pkg::POS_W-1:0]     addr,
  input  logic [pfe_pkg::BYTE_W-1:0]    wdata,
  output logic [pfe_pkg::BYTE_W-1:0]    rdata
);

  logic [pfe_pkg::BYTE_W-1:0] mem [pfe_pkg::MAX_ROW_BYTES];
  logic [pfe_pkg::BYTE_W-1:0] rdata_r;

  // Read returns the old entry, then the new sample replaces it.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r    <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/pfe_predict.sv @@
// Filter predictor and difference: None, Sub, Up, Average and Paeth.
module pfe_predict (
  input  logic [pfe_pkg::FT_W-1:0]    ft,
  input  pfe_pkg::nbr_t               nbr,
  input  logic [pfe_pkg::BYTE_W-1:0]  target,
  output logic [pfe_pkg::BYTE_W-1:0]  diff
);

  logic [pfe_pkg::BYTE_W-1:0] pa;
  logic [pfe_pkg::BYTE_W-1:0] pb;
  logic [pfe_pkg::BYTE_W:0]   pc;
  logic [pfe_pkg::BYTE_W:0]   sum_ab;
  logic [pfe_pkg::BYTE_W:0]   twice_c;
  logic [pfe_pkg::BYTE_W-1:0] paeth;
  logic [pfe_pkg::BYTE_W-1:0] pred;

  always_comb begin
    sum_ab  = {1'b0, nbr.left} + {1'b0, nbr.up};
    twice_c = {nbr.upleft, 1'b0};
    pa = (nbr.up > nbr.upleft) ? nbr.up - nbr.upleft : nbr.upleft - nbr.up;
    pb = (nbr.left > nbr.upleft) ? nbr.left - nbr.upleft : nbr.upleft - nbr.left;
    pc = (sum_ab > twice_c) ? sum_ab - twice_c : twice_c - sum_ab;
    // Ties go to left, then up, then up-left.
    if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc) begin
      paeth = nbr.left;
    end else if ({1'b0, pb} <= pc) begin
      paeth = nbr.up;
    end else begin
      paeth = nbr.upleft;
    end

    case (ft)
      pfe_pkg::FT_SUB:     pred = nbr.left;
      pfe_pkg::FT_UP:      pred = nbr.up;
      pfe_pkg::FT_AVERAGE: pred = sum_ab[pfe_pkg::BYTE_W:1];
      pfe_pkg::FT_PAETH:   pred = paeth;
      default:             pred = '0;
    endcase

    diff = target - pred;
  end

endmodule

@@ src/pfe_checker.sv @@
// Port-level assertions on the result channel, bound to the encoder top level.
module pfe_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pfe_pkg::BYTE_W-1:0]    out_byte,
  input logic                          out_is_tag,
  input logic                          out_last,
  input logic                          out_eoi
);

  // A tag is never last, never end of image, and carries a defined filter code.
  a_tag_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_tag |->
      !out_last && !out_eoi && out_byte <= pfe_pkg::BYTE_W'(pfe_pkg::FT_PAETH))
    else $error("tag result malformed");

  // Every filtered byte closes its sample's results.
  a_byte_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_tag |-> out_last)
    else $error("filtered byte without last");

  // The filtered byte follows its tag immediately.
  a_tag_then_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_is_tag |=> out_valid && !out_is_tag)
    else $error("tag not followed by its filtered byte");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_byte) && $stable(out_is_tag) && $stable(out_eoi))
    else $error("stalled result changed");

endmodule

bind png_scanline_filter_encoder_unit pfe_checker u_pfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .out_is_tag (out_ch.is_tag),
  .out_last   (out_ch.last),
  .out_eoi    (out_ch.end_of_image)
);

@@ sim/tb_png_scanline_filter_encoder_unit.sv @@
// Self-checking testbench of the PNG scanline filter encoder: sample stream in, filtered rows out.
module tb_png_scanline_filter_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [pfe_pkg::BYTE_W-1:0] sample_t;

  // One byte on the result channel: the row tag or a filtered sample.
  typedef struct packed {
    sample_t value;
    logic    is_tag;
    logic    last;
    logic    eoi;
  } coded_byte_t;

  localparam int unsigned RANDOM_ITEMS    = 500;
  localparam int unsigned TAIL_ITEMS      = 60;
  localparam int unsigned WIDE_ROW_ITEMS  = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned STALL_LIMIT     = 3000;
  localparam int unsigned SETTLE_CYCLES   = 10;

  // Filter predictor plus the queue of bytes it expects on the result channel.
  class scanline_filter_check;
    logic [pfe_pkg::FT_W-1:0]  filt;
    logic [pfe_pkg::BPP_W-1:0] lanes_reg;
    logic [pfe_pkg::IW_W-1:0]  width_reg;
    logic [pfe_pkg::IH_W-1:0]  height_reg;
    sample_t                   line_buf [pfe_pkg::MAX_ROW_BYTES];
    sample_t                   left_q [pfe_pkg::MAX_CHANNELS];
    sample_t                   upleft_q [pfe_pkg::MAX_CHANNELS];
    int unsigned               col;
    int unsigned               row;
    int unsigned               written_top;
    coded_byte_t               due_bytes [$];
    int unsigned               bad_results;

    function new();
      filt        = pfe_pkg::FT_RESET;
      lanes_reg   = pfe_pkg::BPP_RESET;
      width_reg   = pfe_pkg::IW_RESET;
      height_reg  = pfe_pkg::IH_RESET;
      col         = 0;
      row         = 0;
      written_top = 0;
      bad_results = 0;
      foreach (line_buf[i]) line_buf[i] = '0;
      foreach (left_q[i]) left_q[i] = '0;
      foreach (upleft_q[i]) upleft_q[i] = '0;
    endfunction

    function void write_reg(logic [pfe_pkg::REG_IDX_W-1:0] idx,
                            logic [pfe_pkg::DATA_W-1:0] val);
      unique case (idx)
        pfe_pkg::REG_FILTER_TYPE:     filt = val[pfe_pkg::FT_W-1:0];
        pfe_pkg::REG_BYTES_PER_PIXEL: lanes_reg = val[pfe_pkg::BPP_W-1:0];
        pfe_pkg::REG_IMAGE_WIDTH:     width_reg = val[pfe_pkg::IW_W-1:0];
        pfe_pkg::REG_IMAGE_HEIGHT:    height_reg = val[pfe_pkg::IH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned lane_count();
      if (lanes_reg == 0) return 1;
      if (lanes_reg > pfe_pkg::MAX_CHANNELS) return pfe_pkg::MAX_CHANNELS;
      return lanes_reg;
    endfunction

    function int unsigned row_bytes();
      int unsigned n;
      n = lane_count() * ((width_reg == 0) ? 1 : width_reg);
      return (n > pfe_pkg::MAX_ROW_BYTES) ? pfe_pkg::MAX_ROW_BYTES : n;
    endfunction

    function int unsigned row_count();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // True when the next sample lands on column 0 of row 0.
    function bit at_image_start();
      if (col >= row_bytes()) return (row + 1 >= row_count());
      return (col == 0) && (row == 0 || row >= row_count());
    endfunction

    // True when the next sample sits below row 0 of a row longer than the
    // stretch of line store written so far.
    function bit stale_risk();
      int unsigned c, r;
      c = col;
      r = row;
      if (c >= row_bytes()) begin
        c = 0;
        r++;
      end
      if (r >= row_count()) r = 0;
      return (r != 0) && (row_bytes() > written_top);
    endfunction

    // Ties go to left, then up, then up-left.
    function sample_t paeth_pick(sample_t a, sample_t b, sample_t c);
      int da, db, dc;
      da = int'(b) - int'(c);
      db = int'(a) - int'(c);
      dc = int'(a) + int'(b) - 2 * int'(c);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
    endfunction

    // Work out the bytes one accepted sample produces and queue them.
    function void take_sample(sample_t sample);
      int unsigned              lanes, stride, h, pos, k;
      logic [pfe_pkg::FT_W-1:0] ft;
      sample_t                  left, up, upleft, pred;
      coded_byte_t              r;
      lanes  = lane_count();
      stride = row_bytes();
      h      = row_count();
      ft     = (filt > pfe_pkg::FT_PAETH) ? pfe_pkg::FT_NONE : filt;
      // Close a row that a smaller setting has cut short; restart a shortened image.
      if (col >= stride) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      pos = col;
      if (pos == 0) begin
        r.value  = sample_t'(ft);
        r.is_tag = 1'b1;
        r.last   = 1'b0;
        r.eoi    = 1'b0;
        due_bytes = {due_bytes, r};
      end
      up     = (row == 0) ? '0 : line_buf[pos];
      left   = (pos < lanes) ? '0 : left_q[lanes-1];
      upleft = (pos < lanes || row == 0) ? '0 : upleft_q[lanes-1];
      case (ft)
        pfe_pkg::FT_SUB:     pred = left;
        pfe_pkg::FT_UP:      pred = up;
        pfe_pkg::FT_AVERAGE: pred = sample_t'((int'(left) + int'(up)) >> 1);
        pfe_pkg::FT_PAETH:   pred = paeth_pick(left, up, upleft);
        default:             pred = '0;
      endcase
      r.value  = sample - pred;
      r.is_tag = 1'b0;
      r.last   = 1'b1;
      r.eoi    = (row == h - 1) && (pos == stride - 1);
      due_bytes = {due_bytes, r};
      for (k = pfe_pkg::MAX_CHANNELS - 1; k > 0; k--) begin
        left_q[k]   = left_q[k-1];
        upleft_q[k] = upleft_q[k-1];
      end
      left_q[0]     = sample;
      upleft_q[0]   = up;
      line_buf[pos] = sample;
      if (pos + 1 > written_top) written_top = pos + 1;
      col = pos + 1;
      if (col >= stride) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void flag(string msg);
      bad_results++;
      if (bad_results <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    // Compare one transferred result with the oldest queued byte.
    function void match_result(sample_t b, logic tag, logic lst, logic eoi);
      coded_byte_t want;
      if (due_bytes.size() == 0) begin
        flag($sformatf("result with nothing queued: byte %02h tag %b last %b eoi %b",
                       b, tag, lst, eoi));
        return;
      end
      want = due_bytes.pop_front();
      if (want.value !== b || want.is_tag !== tag || want.last !== lst ||
          want.eoi !== eoi)
        flag($sformatf({"expected byte %02h tag %b last %b eoi %b, ",
                        "got byte %02h tag %b last %b eoi %b"},
                       want.value, want.is_tag, want.last, want.eoi,
                       b, tag, lst, eoi));
    endfunction

    function int unsigned pending();
      return due_bytes.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [pfe_pkg::ADDR_W-1:0]   paddr;
  logic [pfe_pkg::DATA_W-1:0]   pwdata;
  logic [pfe_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  pfe_in_if  in_bus ();
  pfe_out_if out_bus ();

  scanline_filter_check flow;

  // hold_receiver asks the receiver for one long hold-off; steady_tail ends all idling.
  bit      hold_receiver;
  bit      steady_tail;
  sample_t recent;
  sample_t edge_rows [4];
  sample_t paeth_rows [12];

  png_scanline_filter_encoder_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sample both channels at the falling edge: everything is stable there, and a
  // valid/ready pair seen here is the transfer at the next rising edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) flow.take_sample(in_bus.sample_byte);
      if (out_bus.valid && out_bus.ready)
        flow.match_result(out_bus.out_byte, out_bus.is_tag, out_bus.last,
                          out_bus.end_of_image);
    end
  end

  // Watchdog: end the run once nothing has moved on any port for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_png_scanline_filter_encoder_unit: done, errors");
    $finish;
  end

  // Receiver: random ready bursts, one long hold-off on request, none in the tail.
  initial begin
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_receiver) begin
        // Hold off while the sender keeps offering, so the pipeline fills and stalls in_ch.
        out_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_receiver = 1'b0;
      end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Mix of extremes, repeats and near-repeats (to hit Paeth ties) and plain random bytes.
  function automatic sample_t pick_sample();
    sample_t v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2:       v = recent;
      3:       v = recent + sample_t'($urandom_range(0, 3));
      default: v = sample_t'($urandom);
    endcase
    recent = v;
    return v;
  endfunction

  // Mostly small extents, now and then zero or the field's top value.
  function automatic int unsigned pick_extent(int unsigned top, int unsigned usual);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(1, usual);
    endcase
  endfunction

  // Offer one sample and hold it until the transfer; return at that edge.
  task automatic push_sample(input sample_t v);
    if (!steady_tail && !hold_receiver && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.sample_byte <= v;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every queued result has been transferred.
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (flow.pending() != 0);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic write_register(input logic [pfe_pkg::REG_IDX_W-1:0] idx,
                                input logic [pfe_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    flow.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Pad with random samples until the next one opens a fresh image.
  task automatic align_to_image();
    while (!flow.at_image_start()) push_sample(pick_sample());
  endtask

  task automatic shuffle_settings();
    if ($urandom_range(0, 1) == 0)
      write_register(pfe_pkg::REG_FILTER_TYPE,
                     ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 7));
    if ($urandom_range(0, 2) == 0)
      write_register(pfe_pkg::REG_BYTES_PER_PIXEL, $urandom_range(0, 7));
    if ($urandom_range(0, 2) == 0)
      write_register(pfe_pkg::REG_IMAGE_WIDTH, pick_extent(4095, 6));
    if ($urandom_range(0, 2) == 0)
      write_register(pfe_pkg::REG_IMAGE_HEIGHT, pick_extent(65535, 4));
    // A row grown past the written part of the line store inside an image
    // would read bytes never stored; restart at row 0 instead.
    if (flow.stale_risk()) write_register(pfe_pkg::REG_IMAGE_HEIGHT, 32'd1);
  endtask

  task automatic send_rows(input int unsigned count, input bit paeth);
    int unsigned k;
    for (k = 0; k < count; k++) push_sample(paeth ? paeth_rows[k] : edge_rows[k]);
  endtask

  initial begin
    int unsigned k, len, sent, phase;
    flow = new();
    hold_receiver = 1'b0;
    steady_tail   = 1'b0;
    recent        = '0;
    edge_rows     = '{8'hFF, 8'h00, 8'h00, 8'hFF};
    // Three 2x2 images whose last sample lands on a Paeth tie:
    // left/up tie (left wins), up/up-left tie (up wins), up-left nearest.
    paeth_rows    = '{8'd10, 8'd20, 8'd20, 8'd77,
                      8'd10, 8'd30, 8'd0, 8'd77,
                      8'd100, 8'd200, 8'd0, 8'd77};
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.sample_byte <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no filter, 4 bytes per pixel, a single one-pixel row.
    push_sample(8'h00);
    push_sample(8'hFF);
    push_sample(8'h80);
    push_sample(8'h7F);
    settle();

    // Start of a saturated row: undefined filter, oversized pixel, widest and
    // zero-height image.
    write_register(pfe_pkg::REG_FILTER_TYPE, 32'd7);
    write_register(pfe_pkg::REG_BYTES_PER_PIXEL, 32'd7);
    write_register(pfe_pkg::REG_IMAGE_WIDTH, 32'd4095);
    write_register(pfe_pkg::REG_IMAGE_HEIGHT, 32'd0);
    for (k = 0; k < WIDE_ROW_ITEMS; k++) push_sample(pick_sample());
    settle();

    // Change settings mid-row into a very tall image.
    write_register(pfe_pkg::REG_FILTER_TYPE, pfe_pkg::DATA_W'(pfe_pkg::FT_NONE));
    write_register(pfe_pkg::REG_BYTES_PER_PIXEL, 32'd3);
    write_register(pfe_pkg::REG_IMAGE_WIDTH, 32'd2);
    write_register(pfe_pkg::REG_IMAGE_HEIGHT, 32'd65535);
    push_sample(8'hFF);
    push_sample(8'h00);
    settle();

    // Small 2x2 images per filter; zero pixel size and zero width act as one.
    write_register(pfe_pkg::REG_FILTER_TYPE, pfe_pkg::DATA_W'(pfe_pkg::FT_SUB));
    write_register(pfe_pkg::REG_BYTES_PER_PIXEL, 32'd0);
    write_register(pfe_pkg::REG_IMAGE_HEIGHT, 32'd2);
    align_to_image();
    send_rows(4, 1'b0);
    settle();

    write_register(pfe_pkg::REG_FILTER_TYPE, pfe_pkg::DATA_W'(pfe_pkg::FT_UP));
    write_register(pfe_pkg::REG_BYTES_PER_PIXEL, 32'd2);
    write_register(pfe_pkg::REG_IMAGE_WIDTH, 32'd0);
    align_to_image();
    send_rows(4, 1'b0);
    settle();

    write_register(pfe_pkg::REG_FILTER_TYPE, pfe_pkg::DATA_W'(pfe_pkg::FT_AVERAGE));
    write_register(pfe_pkg::REG_BYTES_PER_PIXEL, 32'd1);
    write_register(pfe_pkg::REG_IMAGE_WIDTH, 32'd2);
    align_to_image();
    send_rows(4, 1'b0);
    settle();

    write_register(pfe_pkg::REG_FILTER_TYPE, pfe_pkg::DATA_W'(pfe_pkg::FT_PAETH));
    align_to_image();
    send_rows(12, 1'b1);
    settle();

    // Random phases: new settings while idle, often mid-row or mid-image.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent + TAIL_ITEMS >= RANDOM_ITEMS) steady_tail = 1'b1;
      shuffle_settings();
      len = $urandom_range(4, 40);
      if (phase == 4) begin
        hold_receiver = 1'b1;
        len = 60;
      end
      for (k = 0; k < len; k++) push_sample(pick_sample());
      sent += len;
      phase++;
      settle();
    end

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (flow.bad_results == 0)
      $display("tb_png_scanline_filter_encoder_unit: done, clean");
    else
      $display("tb_png_scanline_filter_encoder_unit: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
src/pfe_pkg.sv
src/pfe_in_if.sv
src/pfe_out_if.sv
src/pfe_line_store.sv
src/pfe_predict.sv
src/png_scanline_filter_encoder_unit.sv
src/pfe_checker.sv
sim/tb_png_scanline_filter_encoder_unit.sv
